### sv/joystick_servo_jog_stepper_defines.svh
// assertion macros shared by the jog stepper modules
`ifndef JOYSTICK_SERVO_JOG_STEPPER_DEFINES_SVH
`define JOYSTICK_SERVO_JOG_STEPPER_DEFINES_SVH

`ifndef SYNTHESIS

// property checked on every clock edge outside reset
`define JSJ_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// condition that must never hold outside reset
`define JSJ_ASSERT_NEVER(lbl, cond, msg) \
	`JSJ_ASSERT(lbl, !(cond), msg)

`else

`define JSJ_ASSERT(lbl, prop, msg)
`define JSJ_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

### sv/jsj_pkg.sv
// types and constants of the joystick jog stepper
package jsj_pkg;

	localparam int SampleW   = 12;
	localparam int PosW      = 16;
	localparam int StepW     = 9;
	localparam int StepUpW   = 8;
	localparam int ByteW     = 8;
	localparam int CfgDataW  = 12;
	localparam int CfgIdxW   = 3;
	localparam int WordIdxW  = 2;

	localparam logic [SampleW:0]   DEAD_BAND = 13'd5;
	localparam logic [WordIdxW-1:0] LAST_WORD = 2'd3;
	localparam logic [WordIdxW-1:0] OFF_LO_WORD = 2'd2;

	// reset values of the registers and of the motion state
	localparam logic [SampleW-1:0] MID_RESET  = 12'd2048;
	localparam logic [SampleW-1:0] MIN_RESET  = 12'd0;
	localparam logic [SampleW-1:0] MAX_RESET  = 12'd4095;
	localparam logic [StepUpW-1:0] UP_RESET   = 8'd1;
	localparam logic [StepW-1:0]   DOWN_RESET = 9'h1FF;
	localparam logic [PosW-1:0]    HOME_RESET = 16'd307;
	localparam logic [ByteW-1:0]   BASE_RESET = 8'd6;
	localparam logic [StepW-1:0]   STEP_IDLE  = 9'd0;

	typedef enum logic [CfgIdxW-1:0] {
		REG_MID_POINT     = 3'd0,
		REG_POSITION_MIN  = 3'd1,
		REG_POSITION_MAX  = 3'd2,
		REG_STEP_UP       = 3'd3,
		REG_STEP_DOWN     = 3'd4,
		REG_HOME_POSITION = 3'd5,
		REG_CHANNEL_BASE  = 3'd6
	} cfg_idx_t;

	// one jog command handed from the front end to the write sequencer
	typedef struct packed {
		logic [PosW-1:0]  off;
		logic [ByteW-1:0] base;
	} cmd_t;

endpackage

### sv/joystick_servo_jog_stepper.sv
// top level of the joystick servo jog stepper
// Takes one mapped joystick sample per push and jogs a servo channel.
// The front end picks a direction (up when the sample is above the
// midpoint and rising, down when below and falling, else kept), applies
// the dead band of midpoint plus or minus 5 and the position limits, and
// updates the position in the same cycle the sample is accepted. A moving
// sample leaves a command in a short queue; the write sequencer turns it
// into four byte writes (on low, on high, off low, off high) at
// channel_base onward, last_write flagging the fourth. Rate: a sample is
// accepted in every cycle while the queue has room. The sequencer emits
// one word per cycle while the register side pops, taking the next command
// as the fourth word goes out. A run's first word passes through the queue,
// the command register and the output register. Config words are written
// through cfg_we, cfg_index and cfg_data; the user must write them only while
// the block is idle; it is not enforced. Writes to home_position are ignored.
module joystick_servo_jog_stepper import jsj_pkg::*; #(
	parameter int FifoDepth = 2
) (
	input  logic                clk,
	input  logic                arst_n,
	// config write port
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data,
	// sample side
	input  logic                push,
	output logic                full,
	input  logic [SampleW-1:0]  sample,
	// register write side
	output logic                empty,
	input  logic                pop,
	output logic [ByteW-1:0]    reg_address,
	output logic [ByteW-1:0]    reg_data,
	output logic                last_write
);

	logic take;
	logic cmd_valid;
	cmd_t cmd_in;
	cmd_t cmd_head;
	logic cmd_full;
	logic cmd_empty;
	logic cmd_take;

	// a sample is taken whenever the queue has room, moving or not
	assign full = cmd_full;
	assign take = push && !cmd_full;

	jsj_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.take      (take),
		.sample    (sample),
		.cmd_valid (cmd_valid),
		.cmd       (cmd_in)
	);

	// decouples sample intake from the word sequencer
	jsj_cmd_fifo #(
		.Depth (FifoDepth)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (cmd_valid),
		.wr_cmd (cmd_in),
		.rd     (cmd_take),
		.rd_cmd (cmd_head),
		.full   (cmd_full),
		.empty  (cmd_empty)
	);

	// one word per cycle into the output register while the register side pops
	jsj_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_empty   (cmd_empty),
		.cmd         (cmd_head),
		.cmd_take    (cmd_take),
		.pop         (pop),
		.empty       (empty),
		.reg_address (reg_address),
		.reg_data    (reg_data),
		.last_write  (last_write)
	);

endmodule

### sv/jsj_front.sv
// front end: config registers, direction pick and position update
module jsj_front import jsj_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data,
	input  logic                take,
	input  logic [SampleW-1:0]  sample,
	output logic                cmd_valid,
	output cmd_t                cmd
);

	logic [SampleW-1:0] mid_q, min_q, max_q, last_q;
	logic [StepUpW-1:0] step_up_q;
	logic [StepW-1:0]   step_down_q, step_now_q;
	logic [ByteW-1:0]   base_q;
	logic [PosW-1:0]    pos_q;

	logic               dir_up, dir_dn, outside, go;
	logic [StepW-1:0]   step_nxt, step_up_x;
	logic [PosW-1:0]    off;

	assign step_up_x = {1'b0, step_up_q};
	assign dir_up    = (sample > mid_q) && (sample > last_q);
	assign dir_dn    = (sample < mid_q) && (sample < last_q);

	always_comb begin
		priority if (dir_up) begin
			step_nxt = step_up_x;
		end else if (dir_dn) begin
			step_nxt = step_down_q;
		end else begin
			step_nxt = step_now_q;
		end
	end

	// dead band in 13 bits so that it never wraps at the ends
	assign outside = ({1'b0, sample} > ({1'b0, mid_q} + DEAD_BAND)) ||
	                 (({1'b0, sample} + DEAD_BAND) < {1'b0, mid_q});

	assign go = outside &&
	            (((pos_q <= {4'b0, max_q}) && (step_nxt == step_up_x)) ||
	             ((pos_q >= {4'b0, min_q}) && (step_nxt == step_down_q)));

	assign off = pos_q + {{(PosW-StepW){step_nxt[StepW-1]}}, step_nxt};

	assign cmd_valid = take && go;
	assign cmd.off   = off;
	assign cmd.base  = base_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mid_q       <= MID_RESET;
			min_q       <= MIN_RESET;
			max_q       <= MAX_RESET;
			step_up_q   <= UP_RESET;
			step_down_q <= DOWN_RESET;
			base_q      <= BASE_RESET;
			pos_q       <= HOME_RESET;
			step_now_q  <= STEP_IDLE;
			last_q      <= MID_RESET;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx_t'(cfg_index))
					REG_MID_POINT:     mid_q       <= cfg_data;
					REG_POSITION_MIN:  min_q       <= cfg_data;
					REG_POSITION_MAX:  max_q       <= cfg_data;
					REG_STEP_UP:       step_up_q   <= cfg_data[StepUpW-1:0];
					REG_STEP_DOWN:     step_down_q <= cfg_data[StepW-1:0];
					// home position only matters at reset
					REG_HOME_POSITION: ;
					REG_CHANNEL_BASE:  base_q      <= cfg_data[ByteW-1:0];
					default: ;
				endcase
			end
			if (take) begin
				last_q     <= sample;
				step_now_q <= step_nxt;
				if (go) begin
					pos_q <= off;
				end
			end
		end
	end

endmodule

### sv/jsj_cmd_fifo.sv
// small command queue between front end and write sequencer
`include "joystick_servo_jog_stepper_defines.svh"
module jsj_cmd_fifo import jsj_pkg::*; #(
	parameter int Depth = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr,
	input  cmd_t wr_cmd,
	input  logic rd,
	output cmd_t rd_cmd,
	output logic full,
	output logic empty
);

	localparam int AddrW  = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CountW = $clog2(Depth + 1);
	localparam logic [AddrW-1:0]  LastAddr = AddrW'(Depth - 1);
	localparam logic [CountW-1:0] FullCount = CountW'(Depth);

	cmd_t              mem_q [Depth];
	logic [AddrW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CountW-1:0] count_q;

	assign full   = (count_q == FullCount);
	assign empty  = (count_q == '0);
	assign rd_cmd = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= (wr_ptr_q == LastAddr) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= (rd_ptr_q == LastAddr) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({wr, rd})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	`JSJ_ASSERT(a_count_bound, count_q <= FullCount, "command queue count above depth")
	`JSJ_ASSERT_NEVER(a_no_underflow, rd && empty, "command queue read while empty")
	`JSJ_ASSERT_NEVER(a_no_overflow, wr && full && !rd, "command queue write while full")

endmodule

### sv/jsj_back.sv
// write sequencer: turns one command into four register byte writes
`include "joystick_servo_jog_stepper_defines.svh"
module jsj_back import jsj_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_empty,
	input  cmd_t             cmd,
	output logic             cmd_take,
	input  logic             pop,
	output logic             empty,
	output logic [ByteW-1:0] reg_address,
	output logic [ByteW-1:0] reg_data,
	output logic             last_write
);

	cmd_t                cmd_q;
	logic [WordIdxW-1:0] idx_q;
	logic                busy_q;
	logic                out_valid_q;
	logic [ByteW-1:0]    addr_q, data_q;
	logic                last_q;

	logic                advance;
	logic [ByteW-1:0]    word_data;

	assign advance  = busy_q && (!out_valid_q || pop);
	assign cmd_take = !cmd_empty && (!busy_q || (advance && idx_q == LAST_WORD));

	// on time bytes are zero, then off time low and high
	always_comb begin
		unique case (idx_q)
			OFF_LO_WORD: word_data = cmd_q.off[ByteW-1:0];
			LAST_WORD:   word_data = cmd_q.off[PosW-1:ByteW];
			default:     word_data = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd_take) begin
			cmd_q <= cmd;
		end
		if (advance) begin
			addr_q <= cmd_q.base + {{(ByteW-WordIdxW){1'b0}}, idx_q};
			data_q <= word_data;
			last_q <= (idx_q == LAST_WORD);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd_take) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (advance) begin
				if (idx_q == LAST_WORD) begin
					busy_q <= 1'b0;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign empty       = !out_valid_q;
	assign reg_address = addr_q;
	assign reg_data    = data_q;
	assign last_write  = last_q;

	`JSJ_ASSERT(a_last_word, (advance && idx_q == LAST_WORD) |=> (out_valid_q && last_q), "fourth word not marked last")
	`JSJ_ASSERT(a_take_gap, (busy_q && idx_q != LAST_WORD) |-> !cmd_take, "command taken mid run")

endmodule

### test/tb.sv
// self-checking testbench of the joystick servo jog stepper
module tb;
	import jsj_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// index with no register behind it, writes to it must be dropped
	localparam logic [CfgIdxW-1:0] REG_UNUSED = 3'd7;
	// cycles allowed after the last expected word before the block counts as idle
	localparam int SETTLE_CYCLES = 6;
	// how long the register side refuses words in the backpressure test
	localparam int LONG_HOLD = 100;

	// one byte write as it leaves the block
	typedef struct packed {
		logic [ByteW-1:0] addr;
		logic [ByteW-1:0] data;
		logic             last;
	} reg_write_t;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [CfgIdxW-1:0]  cfg_index;
	logic [CfgDataW-1:0] cfg_data;
	logic                push;
	logic                full;
	logic [SampleW-1:0]  sample;
	logic                empty;
	logic                pop;
	logic [ByteW-1:0]    reg_address;
	logic [ByteW-1:0]    reg_data;
	logic                last_write;

	// byte writes the jog logic should produce, oldest first
	reg_write_t pending_writes[$];

	// shadow copy of the register file
	int mid_cfg;
	int min_cfg;
	int max_cfg;
	int up_cfg;
	int down_cfg;
	int home_cfg;
	int base_cfg;

	// shadow copy of the motion state
	logic [PosW-1:0] jog_pos;
	int              step_now;
	int              prev_sample;

	int  mismatches;
	int  samples_sent;
	bit  steady;
	int  hold_request;

	joystick_servo_jog_stepper DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.push       (push),
		.full       (full),
		.sample     (sample),
		.empty      (empty),
		.pop        (pop),
		.reg_address(reg_address),
		.reg_data   (reg_data),
		.last_write (last_write)
	);

	always #5 clk = ~clk;

	// direction pick, dead band, limit test and the four writes of one move
	function automatic void predict_jog(input logic [SampleW-1:0] s_in);
		int              s;
		bit              outside;
		bit              go;
		logic [PosW-1:0] off;
		s = s_in;
		// rising above center jogs up, falling below center jogs down, else keep
		if (s > mid_cfg && s > prev_sample) begin
			step_now = up_cfg;
		end else if (s < mid_cfg && s < prev_sample) begin
			step_now = down_cfg;
		end
		// near the ends of the range one side of the dead band cannot be reached
		outside = (s > mid_cfg + 5) || (s < mid_cfg - 5);
		// up branch first; a zero step can match either branch and writes in place
		go = outside && ((int'(jog_pos) <= max_cfg && step_now == up_cfg) ||
			(int'(jog_pos) >= min_cfg && step_now == down_cfg));
		prev_sample = s;
		if (go) begin
			// 16-bit add, a negative step wraps through zero
			off = PosW'(int'(jog_pos) + step_now);
			pending_writes.push_back('{ByteW'(base_cfg), '0, 1'b0});
			pending_writes.push_back('{ByteW'(base_cfg + 1), '0, 1'b0});
			pending_writes.push_back('{ByteW'(base_cfg + 2), off[7:0], 1'b0});
			pending_writes.push_back('{ByteW'(base_cfg + 3), off[15:8], 1'b1});
			jog_pos = off;
		end
	endfunction

	function automatic void report_mismatch(input string field, input int want, input int got);
		mismatches++;
		if (mismatches <= 10) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $realtime, field, want, got);
		end
	endfunction

	// check every word the block hands over against the oldest expectation
	always @(posedge clk) begin
		reg_write_t want;
		if (arst_n && pop && !empty) begin
			if (pending_writes.size() == 0) begin
				report_mismatch("unexpected word, reg_address", 0, reg_address);
			end else begin
				want = pending_writes.pop_front();
				if (reg_address !== want.addr) report_mismatch("reg_address", want.addr, reg_address);
				if (reg_data !== want.data) report_mismatch("reg_data", want.data, reg_data);
				if (last_write !== want.last) report_mismatch("last_write", want.last, last_write);
			end
		end
	end

	// register side: random stalls, a steady stretch, and the long hold on request
	initial begin
		int hold_left;
		hold_left = 0;
		pop = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				pop = 1'b0;
				hold_left--;
			end else begin
				pop = steady || ($urandom_range(0, 99) >= 25);
			end
		end
	end

	// offer one sample, maybe after a random gap, and wait until it is taken
	task automatic send_sample(input logic [SampleW-1:0] s);
		@(negedge clk);
		if (!steady && $urandom_range(0, 99) < 25) begin
			push = 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		push = 1'b1;
		sample = s;
		do @(posedge clk); while (full);
		predict_jog(s);
		samples_sent++;
	endtask

	// stop offering samples and let every expected word come out
	task automatic drain;
		@(negedge clk);
		push = 1'b0;
		while (pending_writes.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// one register write, only ever called with the block idle
	task automatic write_register(input logic [CfgIdxW-1:0] idx,
		input logic [CfgDataW-1:0] value);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		@(posedge clk);
		case (idx)
			REG_MID_POINT:     mid_cfg = value;
			REG_POSITION_MIN:  min_cfg = value;
			REG_POSITION_MAX:  max_cfg = value;
			REG_STEP_UP:       up_cfg = value[StepUpW-1:0];
			REG_STEP_DOWN:     down_cfg = int'($signed(value[StepW-1:0]));
			// home only matters at reset, the live position is left alone
			REG_HOME_POSITION: home_cfg = value;
			REG_CHANNEL_BASE:  base_cfg = value[ByteW-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// reset settings: dead band edges, both directions, kept direction, sample extremes
	task automatic test_reset_defaults;
		send_sample(12'd2048);  // at center, nothing
		send_sample(12'd2053);  // rising inside the band, direction set but no move
		send_sample(12'd2054);  // first sample outside the band
		send_sample(12'd4095);
		send_sample(12'd4095);  // held, direction kept
		send_sample(12'd2049);  // back inside the band
		send_sample(12'd0);     // falls below, jog down
		send_sample(12'd0);
		send_sample(12'd2043);  // inside the band on the low side
		send_sample(12'd2042);  // falling and just outside
	endtask

	// zero step up, positive step down, dead band at both ends, address wrap
	task automatic test_register_extremes;
		drain();
		write_register(REG_MID_POINT, 12'd0);
		write_register(REG_POSITION_MIN, 12'd0);
		write_register(REG_POSITION_MAX, 12'd4095);
		write_register(REG_STEP_UP, 12'hf00);       // junk above bit 7, step of zero
		write_register(REG_STEP_DOWN, 12'he05);     // positive step taken as given
		write_register(REG_HOME_POSITION, 12'd4095);
		write_register(REG_CHANNEL_BASE, 12'd254);  // addresses wrap past 255
		write_register(REG_UNUSED, 12'hfff);        // dropped
		send_sample(12'd0);     // center at zero, nothing is low enough
		send_sample(12'd4095);  // zero step matches, write in place
		send_sample(12'd6);
		drain();
		write_register(REG_MID_POINT, 12'd4095);
		send_sample(12'd4095);  // center at the top, nothing is high enough
		send_sample(12'd0);     // falling, positive down step moves upward
		send_sample(12'd4089);
		send_sample(12'd4090);  // inside the band
	endtask

	// position runs through zero and back, up limit blocks a move
	task automatic test_position_wrap;
		drain();
		write_register(REG_MID_POINT, 12'd2048);
		write_register(REG_STEP_DOWN, 12'h101);     // -255
		write_register(REG_STEP_UP, 12'd255);
		write_register(REG_CHANNEL_BASE, 12'd252);
		send_sample(12'd100);
		send_sample(12'd100);   // goes below zero and wraps
		send_sample(12'd100);
		send_sample(12'd4000);  // jog up refused, position far above the max
		drain();
		write_register(REG_STEP_DOWN, 12'h0ff);     // +255 on the down branch
		send_sample(12'd100);
		send_sample(12'd100);   // wraps back over the top
	endtask

	// register side stops for a long while, sender keeps pushing until full stalls it
	task automatic test_backpressure;
		int n;
		drain();
		write_register(REG_MID_POINT, 12'd2048);
		write_register(REG_POSITION_MIN, 12'd0);
		write_register(REG_POSITION_MAX, 12'd4095);
		write_register(REG_STEP_UP, 12'd3);
		write_register(REG_STEP_DOWN, 12'h1fe);     // -2
		write_register(REG_CHANNEL_BASE, 12'd6);
		steady = 1'b1;
		hold_request = LONG_HOLD;
		send_sample(12'd1000);
		send_sample(12'd3000);
		for (n = 0; n < 18; n++) begin
			send_sample(12'd3000);
		end
		drain();
		steady = 1'b0;
	endtask

	// fresh settings for a random phase, extremes now and then
	task automatic randomize_registers;
		logic [CfgDataW-1:0] junk;
		int                  k;
		drain();
		case ($urandom_range(0, 9))
			0: write_register(REG_MID_POINT, 12'd0);
			1: write_register(REG_MID_POINT, 12'd4095);
			default: write_register(REG_MID_POINT, CfgDataW'($urandom_range(0, 4095)));
		endcase
		case ($urandom_range(0, 19))
			0: write_register(REG_POSITION_MIN, 12'd4095);
			1, 2, 3: write_register(REG_POSITION_MIN, 12'd0);
			default: write_register(REG_POSITION_MIN, CfgDataW'($urandom_range(0, 1500)));
		endcase
		case ($urandom_range(0, 19))
			0: write_register(REG_POSITION_MAX, 12'd0);
			1, 2, 3: write_register(REG_POSITION_MAX, 12'd4095);
			default: write_register(REG_POSITION_MAX, CfgDataW'($urandom_range(2500, 4095)));
		endcase
		// narrow registers get random bits above their width
		junk = CfgDataW'($urandom_range(0, 4095));
		case ($urandom_range(0, 9))
			0: junk[StepUpW-1:0] = 8'd0;
			1: junk[StepUpW-1:0] = 8'd255;
			default: junk[StepUpW-1:0] = StepUpW'($urandom_range(1, 254));
		endcase
		write_register(REG_STEP_UP, junk);
		junk = CfgDataW'($urandom_range(0, 4095));
		k = $urandom_range(1, 255);
		case ($urandom_range(0, 9))
			0: junk[StepW-1:0] = STEP_IDLE;
			1: junk[StepW-1:0] = 9'h101;
			2: junk[StepW-1:0] = StepW'(k);
			default: junk[StepW-1:0] = StepW'(-k);
		endcase
		write_register(REG_STEP_DOWN, junk);
		write_register(REG_HOME_POSITION, CfgDataW'($urandom_range(0, 4095)));
		junk = CfgDataW'($urandom_range(0, 4095));
		write_register(REG_CHANNEL_BASE, junk);
		write_register(REG_UNUSED, CfgDataW'($urandom_range(0, 4095)));
	endtask

	// mostly jog runs beyond the dead band, some noise and some samples near the band
	task automatic test_random_jogging;
		int  phase;
		int  first_sample;
		int  phase_items;
		int  run_len;
		int  lo;
		int  hi;
		int  s;
		int  n;
		int  kind;
		bit  go_up;
		phase = 0;
		first_sample = samples_sent;
		while ((samples_sent - first_sample < 150) && phase < 14) begin
			randomize_registers();
			// one phase runs without any idling on either side
			steady = (phase == 2);
			phase_items = 0;
			while (phase_items < 30) begin
				kind = $urandom_range(0, 99);
				if (kind < 75) begin
					go_up = $urandom_range(0, 1);
					// with the center near an end only one side is reachable
					if (go_up && mid_cfg + 6 > 4095) go_up = 1'b0;
					if (!go_up && mid_cfg - 6 < 0) go_up = 1'b1;
					lo = go_up ? mid_cfg + 6 : 0;
					hi = go_up ? 4095 : mid_cfg - 6;
					run_len = $urandom_range(2, 8);
					s = $urandom_range(lo, hi);
					for (n = 0; n < run_len; n++) begin
						// hold the stick or move it on the same side
						if (n > 0 && $urandom_range(0, 2) != 0) s = $urandom_range(lo, hi);
						send_sample(SampleW'(s));
					end
					phase_items += run_len;
				end else if (kind < 90) begin
					send_sample(SampleW'($urandom_range(0, 4095)));
					phase_items++;
				end else begin
					s = mid_cfg + $urandom_range(0, 12) - 6;
					if (s < 0) s = 0;
					if (s > 4095) s = 4095;
					send_sample(SampleW'(s));
					phase_items++;
				end
			end
			steady = 1'b0;
			phase++;
		end
	endtask

	// watchdog
	initial begin
		#3_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		push = 1'b0;
		sample = '0;
		mismatches = 0;
		samples_sent = 0;
		steady = 1'b0;
		hold_request = 0;
		// shadow state as it comes out of reset
		mid_cfg = MID_RESET;
		min_cfg = MIN_RESET;
		max_cfg = MAX_RESET;
		up_cfg = UP_RESET;
		down_cfg = int'($signed(DOWN_RESET));
		home_cfg = HOME_RESET;
		base_cfg = BASE_RESET;
		jog_pos = HOME_RESET;
		step_now = int'($signed(STEP_IDLE));
		prev_sample = MID_RESET;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_defaults();
		test_register_extremes();
		test_position_wrap();
		test_backpressure();
		test_random_jogging();

		// everything sent, wait for the last words and a little beyond
		drain();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && pending_writes.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
